[sv/u8r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8r_pkg
// shared types, constants and the lead byte classifier of the utf-8 repair
// stream
// ----------------------------------------------------------------------------
package u8r_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] REP_BYTE0 = 8'hEF;
  localparam logic [7:0] REP_BYTE1 = 8'hBF;
  localparam logic [7:0] REP_BYTE2 = 8'hBD;

  localparam logic [7:0] MASK_1 = 8'h80;
  localparam logic [7:0] MASK_2 = 8'hE0;
  localparam logic [7:0] MASK_3 = 8'hF0;
  localparam logic [7:0] MASK_4 = 8'hF8;
  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] LEAD_4 = 8'hF0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_CODE = 8'h80;

  // one unit of output work: some replacement characters, then raw bytes
  typedef struct packed {
    logic [3:0][7:0] raw;
    logic [2:0]      raw_cnt;
    logic [2:0]      rep_cnt;
    logic            text_end;
  } job_t;

  // sequence length from a lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if ((b & MASK_1) == 8'h00)        len = 3'd1;
    else if ((b & MASK_2) == LEAD_2)  len = 3'd2;
    else if ((b & MASK_3) == LEAD_3)  len = 3'd3;
    else if ((b & MASK_4) == LEAD_4)  len = 3'd4;
    else                              len = 3'd0;
    return len;
  endfunction

endpackage

[sv/u8r_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8r_in_if / u8r_out_if
// valid/ready channels for raw text bytes and repaired bytes
// ----------------------------------------------------------------------------
interface u8r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

[sv/u8r_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8r_front
// takes text bytes, tracks the held sequence and turns each item into a job
// ----------------------------------------------------------------------------
module u8r_front
  import u8r_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  u8r_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         push,
  output job_t         job
);

  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      exp_r, exp_nxt;

  logic [7:0] b;
  logic       eot;
  logic       cont;
  logic [2:0] len;
  logic       pass;
  logic       lead;
  logic       fire;

  assign in_ch.ready = !q_full;
  assign fire = in_ch.valid && in_ch.ready;
  assign b    = in_ch.data_byte;
  assign eot  = in_ch.end_of_text;
  assign cont = (b & CONT_MASK) == CONT_CODE;
  assign len  = lead_len(b);

  always_comb begin
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    exp_nxt      = exp_r;
    job.raw_cnt  = 3'd0;
    job.rep_cnt  = 3'd0;
    job.text_end = eot;
    pass         = 1'b0;
    lead         = 1'b0;

    if (cnt_r != 2'd0) begin
      if (cont) begin
        if ({1'b0, cnt_r} + 3'd1 == exp_r) begin
          pass        = 1'b1;
          job.raw_cnt = {1'b0, cnt_r} + 3'd1;
          cnt_nxt     = 2'd0;
          exp_nxt     = 3'd0;
        end else if (eot || cnt_r == 2'd3) begin
          job.rep_cnt = {1'b0, cnt_r} + 3'd1;
          cnt_nxt     = 2'd0;
          exp_nxt     = 3'd0;
        end else begin
          held_nxt[cnt_r] = b;
          cnt_nxt         = cnt_r + 2'd1;
        end
      end else begin
        job.rep_cnt = {1'b0, cnt_r};
        cnt_nxt     = 2'd0;
        exp_nxt     = 3'd0;
        lead        = 1'b1;
      end
    end else begin
      lead = 1'b1;
    end

    if (lead) begin
      if (len == 3'd1) begin
        job.raw_cnt = 3'd1;
      end else if (len == 3'd0 || eot) begin
        job.rep_cnt = job.rep_cnt + 3'd1;
      end else begin
        held_nxt[0] = b;
        cnt_nxt     = 2'd1;
        exp_nxt     = len;
      end
    end

    if (eot) begin
      cnt_nxt = 2'd0;
      exp_nxt = 3'd0;
    end

    // held bytes first on a completed sequence, then the current byte
    for (int i = 0; i < 4; i++) begin
      if (pass && i < 3 && 2'(i) < cnt_r) job.raw[i] = held_r[i[1:0]];
      else                                 job.raw[i] = b;
    end
  end

  assign push = fire && (job.raw_cnt != 3'd0 || job.rep_cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      exp_r <= 3'd0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) held_r <= held_nxt;
  end

endmodule

[sv/u8r_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8r_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module u8r_queue
  import u8r_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

[sv/u8r_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8r_back
// expands one job into replacement and raw output bytes
// ----------------------------------------------------------------------------
module u8r_back
  import u8r_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  job_t     head,
  input  logic     q_empty,
  output logic     pop,
  u8r_out_if.source out_ch
);

  job_t       job_r;
  logic       vld_r, vld_nxt;
  logic [2:0] rep_r, rep_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [1:0] raw_r, raw_nxt;

  logic in_rep;
  logic last;
  logic fire;

  assign in_rep = rep_r < job_r.rep_cnt;
  assign last   = in_rep
                ? (rep_r + 3'd1 == job_r.rep_cnt && sub_r == 2'd2 && job_r.raw_cnt == 3'd0)
                : ({1'b0, raw_r} + 3'd1 == job_r.raw_cnt);
  assign fire   = vld_r && out_ch.ready;

  always_comb begin
    if (in_rep) begin
      case (sub_r)
        2'd0:    out_ch.out_byte = REP_BYTE0;
        2'd1:    out_ch.out_byte = REP_BYTE1;
        default: out_ch.out_byte = REP_BYTE2;
      endcase
    end else begin
      out_ch.out_byte = job_r.raw[raw_r];
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.run_last  = last;
  assign out_ch.text_done = last && job_r.text_end;

  assign pop = (!vld_r || (fire && last)) && !q_empty;

  always_comb begin
    vld_nxt = vld_r;
    rep_nxt = rep_r;
    sub_nxt = sub_r;
    raw_nxt = raw_r;
    if (pop) begin
      vld_nxt = 1'b1;
      rep_nxt = 3'd0;
      sub_nxt = 2'd0;
      raw_nxt = 2'd0;
    end else if (fire && last) begin
      vld_nxt = 1'b0;
    end else if (fire) begin
      if (in_rep) begin
        if (sub_r == 2'd2) begin
          sub_nxt = 2'd0;
          rep_nxt = rep_r + 3'd1;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end else begin
        raw_nxt = raw_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rep_r <= 3'd0;
      sub_r <= 2'd0;
      raw_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      rep_r <= rep_nxt;
      sub_r <= sub_nxt;
      raw_r <= raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
  end

endmodule

[sv/utf8_repair_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_repair_stream
// repairs a utf-8 text byte stream, broken sequences become EF BF BD
//
// in_ch carries one text byte per item with end_of_text on the final byte.
// out_ch carries repaired bytes; run_last marks the last byte caused by an
// input item, text_done the last byte of the whole text.
// the front classifies each item and holds an open multi-byte sequence; an
// item that produces output becomes a job in a queue of QUEUE_DEPTH entries.
// the back expands a job at one byte per cycle while out_ch is ready: up to
// four replacement characters and up to four raw bytes, at most twelve bytes
// per item. the first output byte is offered from the back's job register,
// loaded from the queue. throughput is one item per cycle while each item
// yields at most one byte and out_ch is ready; items yielding more hold the
// back until all their bytes are sent. when out_ch stalls the back holds its
// byte, the queue fills and then in_ch.ready drops; nothing is lost.
// synchronous reset clears the held sequence, the queue and the back.
// ----------------------------------------------------------------------------
module utf8_repair_stream
  import u8r_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  u8r_in_if.sink    in_ch,
  u8r_out_if.source out_ch
);

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  u8r_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  u8r_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  u8r_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[test/tb_utf8_repair_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_repair_stream
// self-checking bench for the utf-8 repair stream
//
// texts of byte items go to in_ch from a queue. Each accepted item updates a
// local copy of the sequence tracker, which queues the repaired bytes that
// the item should cause. Every byte taken from out_ch is checked against the
// oldest queued byte, together with its run_last and text_done flags.
// A short directed part covers the field extremes, each sequence length,
// stray continuation bytes, invalid leads, broken sequences and texts that end
// inside a sequence. Random texts of mostly well-formed characters then run
// in four phases of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_utf8_repair_stream;
  import u8r_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 64;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_done;
  } repaired_byte_t;

  logic clk;
  logic rst_n;

  u8r_in_if  in_ch ();
  u8r_out_if out_ch ();

  utf8_repair_stream dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  text_byte_t     text_q[$];
  repaired_byte_t repaired_q[$];

  // sequence tracker of the bench
  logic [7:0] hold_buf[3];
  logic [1:0] hold_cnt;
  logic [2:0] hold_span;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned err_cnt;
  int unsigned stuck_cycles;
  logic        in_taken;

  always #5 clk = ~clk;

  function automatic logic [2:0] lead_span(input logic [7:0] b);
    logic [2:0] span;
    if ((b & MASK_1) == 8'h00)        span = 3'd1;
    else if ((b & MASK_2) == LEAD_2)  span = 3'd2;
    else if ((b & MASK_3) == LEAD_3)  span = 3'd3;
    else if ((b & MASK_4) == LEAD_4)  span = 3'd4;
    else                              span = 3'd0;
    return span;
  endfunction

  task automatic repair_byte(input logic [7:0] b, input logic eot);
    logic [7:0]     raw[$];
    logic [7:0]     outb[$];
    logic [2:0]     span;
    int             n_rep;
    repaired_byte_t beat;
    n_rep = 0;
    if (hold_cnt != 2'd0 && (b & CONT_MASK) == CONT_CODE) begin
      if (int'(hold_cnt) + 1 == int'(hold_span)) begin
        for (int i = 0; i < int'(hold_cnt); i++) raw = {raw, hold_buf[i]};
        raw = {raw, b};
        hold_cnt = 2'd0;
        hold_span = 3'd0;
      end else if (eot || hold_cnt == 2'd3) begin
        n_rep = int'(hold_cnt) + 1;
        hold_cnt = 2'd0;
        hold_span = 3'd0;
      end else begin
        hold_buf[hold_cnt] = b;
        hold_cnt = hold_cnt + 2'd1;
      end
    end else begin
      // anything held is broken, then this byte starts afresh
      n_rep = int'(hold_cnt);
      hold_cnt = 2'd0;
      hold_span = 3'd0;
      span = lead_span(b);
      if (span == 3'd1) begin
        raw = {raw, b};
      end else if (span == 3'd0 || eot) begin
        n_rep++;
      end else begin
        hold_buf[0] = b;
        hold_cnt = 2'd1;
        hold_span = span;
      end
    end
    if (eot) begin
      hold_cnt = 2'd0;
      hold_span = 3'd0;
    end
    for (int i = 0; i < n_rep; i++) begin
      outb = {outb, REP_BYTE0, REP_BYTE1, REP_BYTE2};
    end
    foreach (raw[i]) outb = {outb, raw[i]};
    foreach (outb[i]) begin
      beat.data = outb[i];
      beat.run_last = (i == outb.size() - 1);
      beat.text_done = (i == outb.size() - 1) && eot;
      repaired_q = {repaired_q, beat};
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    text_byte_t item;
    item.data = b;
    item.eot = eot;
    text_q = {text_q, item};
    n_queued++;
  endtask

  // one text of random characters, mostly well formed
  task automatic queue_text();
    logic [7:0]  txt[$];
    int unsigned n_chars;
    int unsigned kind;
    int unsigned span;
    int unsigned n_cont;
    n_chars = $urandom_range(8, 1);
    for (int c = 0; c < int'(n_chars); c++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        txt = {txt, 8'($urandom_range(8'h7F, 8'h00))};
      end else if (kind < 80) begin
        span = (kind < 55) ? 2 : (kind < 70) ? 3 : 4;
        n_cont = span - 1;
        if (span == 2)      txt = {txt, LEAD_2 | 8'($urandom_range(31))};
        else if (span == 3) txt = {txt, LEAD_3 | 8'($urandom_range(15))};
        else                txt = {txt, LEAD_4 | 8'($urandom_range(7))};
        for (int k = 0; k < int'(n_cont); k++) txt = {txt, CONT_CODE | 8'($urandom_range(63))};
      end else if (kind < 85) begin
        txt = {txt, CONT_CODE | 8'($urandom_range(63))};
      end else if (kind < 89) begin
        txt = {txt, 8'($urandom_range(8'hFF, 8'hF8))};
      end else if (kind < 96) begin
        // sequence cut short
        span = $urandom_range(4, 2);
        n_cont = $urandom_range(span - 2);
        if (span == 2)      txt = {txt, LEAD_2 | 8'($urandom_range(31))};
        else if (span == 3) txt = {txt, LEAD_3 | 8'($urandom_range(15))};
        else                txt = {txt, LEAD_4 | 8'($urandom_range(7))};
        for (int k = 0; k < int'(n_cont); k++) txt = {txt, CONT_CODE | 8'($urandom_range(63))};
      end else begin
        txt = {txt, 8'($urandom_range(255))};
      end
    end
    foreach (txt[i]) queue_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (n_accepted != n_queued || repaired_q.size() != 0);
  endtask

  always @(negedge clk) begin : drive
    text_byte_t nxt;
    if (!in_ch.valid || in_taken) begin
      if (text_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = text_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.end_of_text <= nxt.eot;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : observe
    repaired_byte_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      repair_byte(in_ch.data_byte, in_ch.end_of_text);
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (repaired_q.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected output byte %02h last %0b done %0b",
                   out_ch.out_byte, out_ch.run_last, out_ch.text_done);
        err_cnt++;
      end else begin
        want = repaired_q.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.run_last !== want.run_last ||
            out_ch.text_done !== want.text_done) begin
          if (err_cnt < 10)
            $display("mismatch: expected byte %02h last %0b done %0b, got %02h last %0b done %0b",
                     want.data, want.run_last, want.text_done,
                     out_ch.out_byte, out_ch.run_last, out_ch.text_done);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("utf8_repair_stream verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned idle_src[4];
    int unsigned idle_snk[4];
    int unsigned target;
    idle_src = '{0, 77, 0, 37};
    idle_snk = '{0, 0, 77, 37};
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    n_queued = 0;
    n_accepted = 0;
    err_cnt = 0;
    stuck_cycles = 0;
    hold_cnt = 2'd0;
    hold_span = 3'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // ascii extremes, then complete two, three and four byte characters
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hC2, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    // stray continuation and invalid leads
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF8, 1'b0);
    // broken by ascii, then three held bytes broken by an invalid lead
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // texts ending inside a sequence, on a lone lead, on plain ascii
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);
    queue_byte(8'hC3, 1'b1);
    queue_byte(8'h5A, 1'b1);

    for (int p = 0; p < 4; p++) begin
      drain();
      @(posedge clk);
      src_idle_pct = idle_src[p];
      snk_stall_pct = idle_snk[p];
      target = n_queued + PHASE_ITEMS;
      while (n_queued < target) queue_text();
    end
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0)
      $display("utf8_repair_stream verification clean");
    else
      $display("utf8_repair_stream verification failed");
    $finish;
  end

endmodule
